// File: rtl/core/scw_pkg.sv
// scw_pkg: shared types and codes for the segment completion watermark block.
// No dependencies; compiled first.
package scw_pkg;

	localparam int OFS_W = 48;
	localparam int LEN_W = 32;
	localparam int OP_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_COMPLETE = 2'd0,
		OP_SET_WM   = 2'd1,
		OP_RESTART  = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic CFG_VOLUME_LENGTH      = 1'b0;
	localparam logic CFG_MAX_SEGMENT_LENGTH = 1'b1;

	localparam logic [LEN_W-1:0] MAX_SEG_RESET = 32'd4194304;

	typedef struct packed {
		logic [OFS_W-1:0] offset;
		logic [LEN_W-1:0] length;
	} entry_t;

endpackage

// File: rtl/core/scw_if.sv
// scw_if: valid/ready channel interfaces for items and results.
// No dependencies.
interface scw_item_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic [47:0]              seg_offset;
	logic [31:0]              seg_length;
	modport source (output valid, op, seg_offset, seg_length, input ready);
	modport sink   (input valid, op, seg_offset, seg_length, output ready);
endinterface

interface scw_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] watermark;
	logic        all_done;
	logic        rejected;
	logic        overflow;
	modport source (output valid, watermark, all_done, rejected, overflow, input ready);
	modport sink   (input valid, watermark, all_done, rejected, overflow, output ready);
endinterface

// File: rtl/core/scw_ram.sv
// scw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scw_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/segment_completion_watermark.sv
// segment_completion_watermark: top level, sequencer around the pending table RAM.
// Depends on scw_pkg, scw_if (scw_item_if, scw_result_if) and scw_ram.
//
// Usage:
//   item channel: op, seg_offset, seg_length. One transaction per op.
//   result channel: watermark, all_done, rejected, overflow; exactly one
//   result transaction per item transaction, in order.
//   Config: cfg_we/cfg_index/cfg_wdata, write only while the block is idle.
// Pending segments live in one RAM as a circular list sorted by offset,
// with a head pointer and a count in flops. Insert walks from the tail,
// moving one entry up per read-then-compare-and-write step; the drain
// pops head entries with the same kind of read-then-compare step.
// Sequencing: an item is taken only in the idle state. Rejected, set-watermark,
// restart and unused ops go straight to the emit state, which loads the
// result register once it is free. A completion inserts, then drains, then
// emits; with a full table it skips the insert and only drains. The RAM's
// registered read sets the read-then-compare step.
// The result sits in an output register; the next item is taken while it
// waits. A stalled receiver holds the block in its final state until the
// register frees.
// Reset clears watermark, done flag, count and head; the RAM needs no clear
// since only entries below the count are ever read.
module segment_completion_watermark #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [47:0]         cfg_wdata,
	scw_item_if.sink            item,
	scw_result_if.source        result
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(TABLE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_DRN_RD, ST_DRN_CMP, ST_EMIT
	} state_t;

	state_t st_q;

	logic [47:0]         vol_q;
	logic [31:0]         maxlen_q;
	logic [47:0]         off_q;
	logic [31:0]         len_q;
	logic [CW-1:0]       k_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       head_q;
	logic [47:0]         wm_q;
	logic                done_q;
	logic                rej_q;
	logic                ovf_q;
	logic                chk_q;
	logic                ovalid_q;
	logic [47:0]         owm_q;
	logic                odone_q;
	logic                orej_q;
	logic                oovf_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	scw_pkg::entry_t     ram_wdata;
	logic [AW-1:0]       ram_raddr;
	scw_pkg::entry_t     ram_rdata;

	logic                take;
	logic                is_cmp;
	logic                done_nx;
	logic                bound_bad;
	scw_pkg::entry_t     new_ent;

	// circular index: (a + b) mod depth, both below depth
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign take      = item.valid && item.ready;
	assign item.ready = (st_q == ST_IDLE);
	assign is_cmp    = (scw_pkg::op_t'(item.op) == scw_pkg::OP_COMPLETE);
	assign bound_bad = (({1'b0, item.seg_offset} + {17'b0, item.seg_length}) > {1'b0, vol_q})
		|| (item.seg_length > maxlen_q);
	assign new_ent   = '{offset: off_q, length: len_q};
	assign done_nx   = done_q || (chk_q && (wm_q >= vol_q));

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wrap(head_q, k_q[AW-1:0]);
		ram_wdata = new_ent;
		ram_raddr = head_q;
		unique case (st_q)
			ST_INS_RD: begin
				if (k_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = wrap(head_q, k_q[AW-1:0] - AW'(1));
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (!(off_q > ram_rdata.offset)) begin
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	scw_ram #(.W($bits(scw_pkg::entry_t)), .D(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q    <= '0;
			maxlen_q <= scw_pkg::MAX_SEG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == scw_pkg::CFG_VOLUME_LENGTH) begin
				vol_q <= cfg_wdata;
			end else begin
				maxlen_q <= cfg_wdata[31:0];
			end
		end
	end

	// sequencer, tracker state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			head_q   <= '0;
			k_q      <= '0;
			wm_q     <= '0;
			done_q   <= 1'b0;
			rej_q    <= 1'b0;
			ovf_q    <= 1'b0;
			chk_q    <= 1'b0;
			ovalid_q <= 1'b0;
			owm_q    <= '0;
			odone_q  <= 1'b0;
			orej_q   <= 1'b0;
			oovf_q   <= 1'b0;
			off_q    <= '0;
			len_q    <= '0;
		end else begin
			// emit reloads the register itself
			if (ovalid_q && result.ready && st_q != ST_EMIT) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						off_q <= item.seg_offset;
						len_q <= item.seg_length;
						k_q   <= cnt_q;
						rej_q <= is_cmp && bound_bad;
						chk_q <= is_cmp && !bound_bad;
						ovf_q <= is_cmp && !bound_bad && (cnt_q == DEPTH_C);
						priority if (!is_cmp || bound_bad) begin
							st_q <= ST_EMIT;
						end else if (cnt_q == DEPTH_C) begin
							st_q <= ST_DRN_RD;
						end else begin
							st_q <= ST_INS_RD;
						end
						unique case (scw_pkg::op_t'(item.op))
							scw_pkg::OP_COMPLETE: ;
							scw_pkg::OP_SET_WM: wm_q <= item.seg_offset;
							scw_pkg::OP_RESTART: begin
								wm_q   <= '0;
								done_q <= 1'b0;
								cnt_q  <= '0;
								head_q <= '0;
							end
							scw_pkg::OP_NOP: ;
						endcase
					end
				end
				ST_INS_RD: begin
					if (k_q == '0) begin
						cnt_q <= cnt_q + CW'(1);
						st_q  <= ST_DRN_RD;
					end else begin
						st_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (off_q > ram_rdata.offset) begin
						cnt_q <= cnt_q + CW'(1);
						st_q  <= ST_DRN_RD;
					end else begin
						k_q  <= k_q - CW'(1);
						st_q <= ST_INS_RD;
					end
				end
				ST_DRN_RD: begin
					st_q <= (cnt_q == '0) ? ST_EMIT : ST_DRN_CMP;
				end
				ST_DRN_CMP: begin
					if (ram_rdata.offset <= wm_q) begin
						if (ram_rdata.offset == wm_q) begin
							wm_q <= wm_q + {16'b0, ram_rdata.length};
						end
						head_q <= wrap(head_q, AW'(1));
						cnt_q  <= cnt_q - CW'(1);
						st_q   <= ST_DRN_RD;
					end else begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || result.ready) begin
						done_q   <= done_nx;
						ovalid_q <= 1'b1;
						owm_q    <= wm_q;
						odone_q  <= done_nx;
						orej_q   <= rej_q;
						oovf_q   <= ovf_q;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid     = ovalid_q;
	assign result.watermark = owm_q;
	assign result.all_done  = odone_q;
	assign result.rejected  = orej_q;
	assign result.overflow  = oovf_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C) else $error("pending count above depth");
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.op == scw_pkg::OP_RESTART) |=> (cnt_q == '0 && wm_q == '0 && !done_q))
		else $error("restart did not clear tracker");
	a_done_set_at_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(st_q == ST_EMIT)) else $error("done set outside emit");
	a_rej_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(orej_q && oovf_q)) else $error("rejected and overflow both set");
`endif
endmodule

// File: dv/tb_top.sv
// tb_top: self-checking bench for segment_completion_watermark.
// Depends on scw_pkg, scw_if and the RTL of the block.
// Predicts each result from a local copy of the tracker state; random idling.
module tb_top;

	localparam int DEPTH   = 32;
	localparam int DRAIN_WAIT = 300; // worst completion: full table moved and drained

	typedef struct {
		scw_pkg::op_t op;
		logic [47:0]  off;
		logic [31:0]  len;
	} seg_item_t;

	typedef struct {
		logic [47:0] wm;
		logic        done;
		logic        rej;
		logic        ovf;
	} wm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [47:0] cfg_wdata = '0;

	scw_item_if   item ();
	scw_result_if result ();

	segment_completion_watermark #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item(item.sink), .result(result.source)
	);

	always #2 clk = ~clk;

	// Local tracker state
	logic [47:0] vol_len;
	logic [31:0] max_len;
	logic [47:0] tbl_off [DEPTH];
	logic [31:0] tbl_len [DEPTH];
	int          tbl_cnt;
	logic [47:0] cur_wm;
	logic        done_sticky;

	seg_item_t  send_q [$];
	wm_result_t wm_expected [$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_overflow = 0;
	int n_reject = 0;
	int n_done = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_cycles = 0;

	function automatic void track_item(seg_item_t it);
		wm_result_t r;
		logic [48:0] ends;
		int pos;
		r.rej = 1'b0;
		r.ovf = 1'b0;
		case (it.op)
			scw_pkg::OP_COMPLETE: begin
				ends = {1'b0, it.off} + {17'd0, it.len};
				if (ends > {1'b0, vol_len} || it.len > max_len) begin
					r.rej = 1'b1;
				end else begin
					if (tbl_cnt >= DEPTH) begin
						r.ovf = 1'b1;
					end else begin
						// new entry goes before equal offsets
						pos = 0;
						while (pos < tbl_cnt && it.off > tbl_off[pos]) pos++;
						for (int k = tbl_cnt; k > pos; k--) begin
							tbl_off[k] = tbl_off[k-1];
							tbl_len[k] = tbl_len[k-1];
						end
						tbl_off[pos] = it.off;
						tbl_len[pos] = it.len;
						tbl_cnt++;
					end
					// pop heads at or below the watermark; exact hit advances it
					while (tbl_cnt > 0 && tbl_off[0] <= cur_wm) begin
						if (tbl_off[0] == cur_wm) cur_wm = cur_wm + {16'd0, tbl_len[0]};
						for (int k = 1; k < tbl_cnt; k++) begin
							tbl_off[k-1] = tbl_off[k];
							tbl_len[k-1] = tbl_len[k];
						end
						tbl_cnt--;
					end
					if (cur_wm >= vol_len) done_sticky = 1'b1;
				end
			end
			scw_pkg::OP_SET_WM: cur_wm = it.off;
			scw_pkg::OP_RESTART: begin
				cur_wm = '0;
				done_sticky = 1'b0;
				tbl_cnt = 0;
			end
			default: ;
		endcase
		r.wm = cur_wm;
		r.done = done_sticky;
		wm_expected.push_back(r);
	endfunction

	// Driver: offers queued items, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.op <= '0;
			item.seg_offset <= '0;
			item.seg_length <= '0;
		end else begin
			if (item.valid && item.ready) begin
				track_item('{scw_pkg::op_t'(item.op), item.seg_offset, item.seg_length});
				n_sent++;
			end
			if (!item.valid || item.ready) begin
				if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					seg_item_t nx;
					nx = send_q.pop_front();
					item.valid <= 1'b1;
					item.op <= nx.op;
					item.seg_offset <= nx.off;
					item.seg_length <= nx.len;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every result transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (wm_expected.size() == 0) begin
					$display("%0t: unexpected result wm=%h", $time, result.watermark);
					errors++;
				end else begin
					wm_result_t e;
					e = wm_expected.pop_front();
					n_checked++;
					if (e.wm !== result.watermark) begin
						$display("%0t: watermark exp %h got %h", $time, e.wm, result.watermark);
						errors++;
					end
					if (e.done !== result.all_done) begin
						$display("%0t: all_done exp %b got %b", $time, e.done, result.all_done);
						errors++;
					end
					if (e.rej !== result.rejected) begin
						$display("%0t: rejected exp %b got %b", $time, e.rej, result.rejected);
						errors++;
					end
					if (e.ovf !== result.overflow) begin
						$display("%0t: overflow exp %b got %b", $time, e.ovf, result.overflow);
						errors++;
					end
					if (e.ovf) n_overflow++;
					if (e.rej) n_reject++;
					if (e.done) n_done++;
				end
			end
			// long hold-off is counted here so the sender keeps pushing meanwhile
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_cycles <= 400;
				result.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic push(scw_pkg::op_t op, logic [47:0] off, logic [31:0] len);
		send_q.push_back('{op, off, len});
	endtask

	task automatic cfg_write(logic idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == scw_pkg::CFG_VOLUME_LENGTH) vol_len = val;
		else max_len = val[31:0];
	endtask

	// sender pause: all results in, then the drain latency
	task automatic wait_quiet();
		while (send_q.size() > 0 || item.valid || wm_expected.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()} >> (16 + $urandom_range(47)));
	endfunction

	// One well-formed run: contiguous segments ending at the volume length,
	// delivered with local shuffling (wide windows overflow the table),
	// plus some noise items mixed in.
	task automatic gen_run(int nseg, int window);
		logic [47:0] lens [$];
		logic [47:0] total, l, cap;
		logic [47:0] offs [$];
		logic [47:0] ln [$];
		logic [47:0] base, acc;
		int j;
		total = '0;
		for (int i = 0; i < nseg; i++) begin
			cap = {16'd0, max_len};
			l = {16'd0, $urandom()} >> $urandom_range(31);
			if (l > cap) l = cap;
			if (l > vol_len - total) l = vol_len - total;
			lens.push_back(l);
			total += l;
		end
		base = vol_len - total;
		push(scw_pkg::OP_RESTART, rand48(), $urandom());
		push(scw_pkg::OP_SET_WM, base, $urandom());
		acc = base;
		foreach (lens[i]) begin
			offs.push_back(acc);
			ln.push_back(lens[i]);
			acc += lens[i];
		end
		for (int i = 0; i < offs.size(); i++) begin
			j = i + $urandom_range(window);
			if (j < offs.size()) begin
				l = offs[i]; offs[i] = offs[j]; offs[j] = l;
				l = ln[i]; ln[i] = ln[j]; ln[j] = l;
			end
		end
		foreach (offs[i]) begin
			push(scw_pkg::OP_COMPLETE, offs[i], ln[i][31:0]);
			case ($urandom_range(19))
				0: push(scw_pkg::OP_COMPLETE, offs[i], ln[i][31:0]);      // duplicate
				1: push(scw_pkg::OP_COMPLETE, rand48(), $urandom());      // likely reject
				2: push(scw_pkg::op_t'($urandom_range(3)), rand48(), $urandom());
				default: ;
			endcase
		end
	endtask

	task automatic run_phase(logic [47:0] vol, logic [31:0] mx, int mode, int items);
		wait_quiet();
		cfg_write(scw_pkg::CFG_VOLUME_LENGTH, vol);
		cfg_write(scw_pkg::CFG_MAX_SEGMENT_LENGTH, {16'd0, mx});
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
			default: begin send_idle_pct = 17; recv_stall_pct = 17; end
		endcase
		while (items > 0) begin
			int n, w;
			n = $urandom_range(4, 40);
			w = ($urandom_range(3) == 0) ? 40 : $urandom_range(4);
			gen_run(n, w);
			items -= n + 2;
			if ($urandom_range(3) == 0) begin
				// let the queue run dry so the sender sometimes idles between runs
				while (send_q.size() > 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		vol_len = '0;
		max_len = scw_pkg::MAX_SEG_RESET;
		tbl_cnt = 0;
		cur_wm = '0;
		done_sticky = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bounds, ordering, equal offsets, below-watermark discard
		cfg_write(scw_pkg::CFG_VOLUME_LENGTH, 48'd1000);
		cfg_write(scw_pkg::CFG_MAX_SEGMENT_LENGTH, 48'd100);
		push(scw_pkg::OP_COMPLETE, 48'd0, 32'd100);
		push(scw_pkg::OP_COMPLETE, 48'd200, 32'd50);
		push(scw_pkg::OP_COMPLETE, 48'd100, 32'd100);
		push(scw_pkg::OP_COMPLETE, 48'd150, 32'd10);
		push(scw_pkg::OP_COMPLETE, 48'd950, 32'd60);
		push(scw_pkg::OP_COMPLETE, 48'd0, 32'd101);
		push(scw_pkg::OP_COMPLETE, 48'd300, 32'd10);
		push(scw_pkg::OP_COMPLETE, 48'd300, 32'd20);
		push(scw_pkg::OP_COMPLETE, 48'd250, 32'd50);
		push(scw_pkg::OP_SET_WM, 48'd1000, 32'd0);
		push(scw_pkg::OP_NOP, '1, '1);
		push(scw_pkg::OP_COMPLETE, 48'd1000, 32'd0);
		push(scw_pkg::OP_COMPLETE, '1, '1);
		push(scw_pkg::OP_RESTART, '1, '1);
		push(scw_pkg::OP_COMPLETE, 48'd990, 32'd10);
		push(scw_pkg::OP_SET_WM, '1, 32'd0);
		push(scw_pkg::OP_COMPLETE, 48'd0, 32'd0);
		push(scw_pkg::OP_RESTART, '0, '0);

		// Long receiver hold-off while the sender keeps offering
		wait_quiet();
		hold_req = hold_req + 1;
		for (int i = 0; i < 20; i++) push(scw_pkg::OP_COMPLETE, 48'(i * 10), 32'd10);

		// Phases over register settings, extremes included
		run_phase('1, '1, 0, 250);
		run_phase('0, '1, 1, 120);
		run_phase(48'd5000, 32'd0, 2, 120);
		run_phase(rand48(), scw_pkg::MAX_SEG_RESET, 3, 250);
		run_phase('1, 32'h8000_0000, 2, 250);
		run_phase(48'h1_0000_0000, '1, 1, 250);
		run_phase(rand48(), $urandom(), 3, 250);
		wait_quiet();

		$display("covered %0d items: %0d rejects, %0d overflows, %0d results with done set",
			n_sent, n_reject, n_overflow, n_done);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout after %0d results", n_checked);
		$display("tb_top: errors");
		$finish;
	end

endmodule
